// ===== hdl/cmti_pkg.sv =====
// Shared constants, types and codes of the cylinder mesh triangle indexer.
package cmti_pkg;

	localparam int CFG_RES_W          = 10;   // stack and sector register width
	localparam int CFG_INDEX_W        = 2;
	localparam int CFG_DATA_W         = 10;
	localparam int N_W                = 21;   // triangle number width
	localparam int Q_W                = N_W - 1;  // quad number width
	localparam int IDX_W              = 21;   // vertex index width
	localparam int TDATA_IN_W         = 24;
	localparam int TDATA_OUT_W        = 64;
	localparam int TUSER_OUT_W        = 2;
	localparam int DIV_STAGES         = CFG_RES_W;  // one quotient bit per stage
	localparam int DEF_MAX_RESOLUTION = 1023;
	localparam int DEF_INDEX_WIDTH    = 21;

	typedef enum logic [1:0] {
		REGION_SIDE   = 2'd0,
		REGION_BOTTOM = 2'd1,
		REGION_TOP    = 2'd2,
		REGION_BEYOND = 2'd3
	} region_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STACK_COUNT     = 2'd0,
		CFG_SECTOR_COUNT    = 2'd1,
		CFG_WITH_BOTTOM_CAP = 2'd2,
		CFG_WITH_TOP_CAP    = 2'd3
	} cfg_index_t;

	// Classification that travels with an item through the divider.
	typedef struct packed {
		region_t              region;
		logic                 odd;
		logic [CFG_RES_W-1:0] fan;
	} tag_t;

endpackage

// ===== hdl/cylinder_mesh_triangle_indexer.sv =====
// Top level: pipelined cylinder mesh triangle to vertex index mapper.
// Throughput: one triangle per cycle unless the output stalls; the ten-stage restoring divider
// that splits the quad number into row and column sets the pipeline depth, not the rate.
// Every stage holds its own valid bit, so bubbles collapse and input keeps flowing
// while a result waits. Reset clears the valid bits and loads the registers 1, 8, 1, 1.
module cylinder_mesh_triangle_indexer
	import cmti_pkg::*;
#(
	parameter int MAX_RESOLUTION = DEF_MAX_RESOLUTION,
	parameter int INDEX_WIDTH    = DEF_INDEX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [20:0] triangle_number
	// output stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [20:0] index_a, [41:21] index_b,
	                                               // [62:42] index_c
	output logic [TUSER_OUT_W-1:0] m_axis_tuser,   // [1:0] region
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Indices wrap at INDEX_WIDTH bits, never wider than the port fields.
	localparam int IdxBits = (INDEX_WIDTH < IDX_W) ? INDEX_WIDTH : IDX_W;
	localparam logic [IDX_W-1:0] IdxMask = IDX_W'((64'd1 << IdxBits) - 64'd1);

	// Stage map: 1 capture, 2 side test, 3 cap test, 4..13 divider, 14 row/column
	// multiply and cap fan, 15 final indices (output register).
	localparam int SDiv0      = 4;
	localparam int SK1        = SDiv0 + DIV_STAGES;
	localparam int NumStages  = SK1 + 1;

	//------------------------------------------------------------------
	// Configuration registers
	//------------------------------------------------------------------
	logic [CFG_RES_W-1:0] stack_count_q;
	logic [CFG_RES_W-1:0] sector_count_q;
	logic                 with_bottom_cap_q;
	logic                 with_top_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q     <= CFG_RES_W'(1);
			sector_count_q    <= CFG_RES_W'(8);
			with_bottom_cap_q <= 1'b1;
			with_top_cap_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_STACK_COUNT:     stack_count_q     <= cfg_data[CFG_RES_W-1:0];
				CFG_SECTOR_COUNT:    sector_count_q    <= cfg_data[CFG_RES_W-1:0];
				CFG_WITH_BOTTOM_CAP: with_bottom_cap_q <= cfg_data[0];
				CFG_WITH_TOP_CAP:    with_top_cap_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the resolution to the supported maximum.
	logic [CFG_RES_W-1:0] u_c;
	logic [CFG_RES_W-1:0] v_c;
	logic [CFG_RES_W:0]   up1;
	logic [CFG_RES_W:0]   vp1;

	always_comb begin
		u_c = (32'(stack_count_q) > MAX_RESOLUTION) ? CFG_RES_W'(MAX_RESOLUTION)
		                                              : stack_count_q;
		v_c = (32'(sector_count_q) > MAX_RESOLUTION) ? CFG_RES_W'(MAX_RESOLUTION)
		                                               : sector_count_q;
		up1 = {1'b0, u_c} + (CFG_RES_W+1)'(1);
		vp1 = {1'b0, v_c} + (CFG_RES_W+1)'(1);
	end

	// Mesh counts derived from the registers, held in registers of their own; items must not
	// reach the stages that read them before they settle, which the block itself does not enforce.
	logic [IDX_W-1:0] sides_q;   // number of side triangles
	logic [IDX_W-1:0] base_q;    // bottom cap centre vertex
	logic [IDX_W-1:0] top_q;     // top cap centre vertex

	always_ff @(posedge clk) begin
		sides_q <= IDX_W'({Q_W'(u_c) * Q_W'(v_c), 1'b0});
		base_q  <= IDX_W'(up1) * IDX_W'(vp1);
		top_q   <= IDX_W'(up1) * IDX_W'(vp1)
		           + (with_bottom_cap_q ? IDX_W'(vp1) : IDX_W'(0));
	end

	//------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or its item moves on
	//------------------------------------------------------------------
	logic [NumStages:1] valid_s;
	logic [NumStages:1] valid_in;
	logic [NumStages:1] ld;

	for (genvar k = 1; k <= NumStages; k++) begin : g_ld
		assign ld[k] = m_axis_tready || !(&valid_s[NumStages:k]);
	end

	assign valid_in = {valid_s[NumStages-1:1], s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int k = 1; k <= NumStages; k++) begin
				if (ld[k]) begin
					valid_s[k] <= valid_in[k];
				end
			end
		end
	end

	assign s_axis_tready = ld[1];

	//------------------------------------------------------------------
	// Stage 1: capture the triangle number, wrapped to the index width
	//------------------------------------------------------------------
	logic [N_W-1:0] n_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			n_s1 <= s_axis_tdata[N_W-1:0] & IdxMask;
		end
	end

	//------------------------------------------------------------------
	// Stage 2: side test and offset into the cap fans
	//------------------------------------------------------------------
	logic           side_s2;
	logic           odd_s2;
	logic [N_W-1:0] m_s2;
	logic [Q_W-1:0] q_s2;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			side_s2 <= n_s1 < sides_q;
			odd_s2  <= n_s1[0];
			m_s2    <= n_s1 - sides_q;
			q_s2    <= n_s1[N_W-1:1];
		end
	end

	//------------------------------------------------------------------
	// Stage 3: bottom and top fan test
	//------------------------------------------------------------------
	logic [N_W:0]   mv;
	logic [N_W-1:0] m2;
	logic           in_bottom;
	logic           in_top;
	tag_t           tag_d;
	tag_t           tag_s3;
	logic [Q_W-1:0] q_s3;

	always_comb begin
		mv        = {1'b0, m_s2} - {1'b0, N_W'(v_c)};
		in_bottom = with_bottom_cap_q && mv[N_W];
		m2        = with_bottom_cap_q ? mv[N_W-1:0] : m_s2;
		in_top    = with_top_cap_q && (m2 < N_W'(v_c));
		tag_d.odd = odd_s2;
		tag_d.fan = in_bottom ? m_s2[CFG_RES_W-1:0] : m2[CFG_RES_W-1:0];
		if (side_s2) begin
			tag_d.region = REGION_SIDE;
		end else if (in_bottom) begin
			tag_d.region = REGION_BOTTOM;
		end else if (in_top) begin
			tag_d.region = REGION_TOP;
		end else begin
			tag_d.region = REGION_BEYOND;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			tag_s3 <= tag_d;
			q_s3   <= q_s2;
		end
	end

	//------------------------------------------------------------------
	// Stages 4..13: restoring divider, quad number by sector count.
	// A side quad lies below V * 2^DIV_STAGES, so the quotient fits.
	//------------------------------------------------------------------
	logic [Q_W-1:0]       div_rem_s [DIV_STAGES];
	logic [CFG_RES_W-1:0] div_quo_s [DIV_STAGES];
	tag_t                 div_tag_s [DIV_STAGES];

	for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
		localparam int Shift = DIV_STAGES - 1 - d;
		logic [Q_W-1:0]       rem_in;
		logic [CFG_RES_W-1:0] quo_in;
		tag_t                 tag_in;
		logic [Q_W-1:0]       dsh;
		logic                 fit;

		if (d == 0) begin : g_first
			assign rem_in = q_s3;
			assign quo_in = '0;
			assign tag_in = tag_s3;
		end else begin : g_next
			assign rem_in = div_rem_s[d-1];
			assign quo_in = div_quo_s[d-1];
			assign tag_in = div_tag_s[d-1];
		end

		assign dsh = Q_W'(v_c) << Shift;
		assign fit = rem_in >= dsh;

		always_ff @(posedge clk) begin
			if (ld[SDiv0+d]) begin
				div_rem_s[d] <= fit ? (rem_in - dsh) : rem_in;
				div_quo_s[d] <= {quo_in[CFG_RES_W-2:0], fit};
				div_tag_s[d] <= tag_in;
			end
		end
	end

	//------------------------------------------------------------------
	// Stage 14: k1 = row * (V+1) + column; cap centre and rim vertices
	//------------------------------------------------------------------
	tag_t                 tag_k;
	logic [CFG_RES_W-1:0] row_k;
	logic [CFG_RES_W-1:0] col_k;
	logic [IDX_W-1:0]     cen_k;
	logic                 wrap_k;

	logic [IDX_W-1:0] k1_s14;
	logic [IDX_W-1:0] cen_s14;
	logic [IDX_W-1:0] p1_s14;
	logic [IDX_W-1:0] p2_s14;
	tag_t             tag_s14;

	always_comb begin
		tag_k  = div_tag_s[DIV_STAGES-1];
		row_k  = div_quo_s[DIV_STAGES-1];
		col_k  = div_rem_s[DIV_STAGES-1][CFG_RES_W-1:0];
		cen_k  = (tag_k.region == REGION_BOTTOM) ? base_q : top_q;
		// last fan triangle closes back onto the first rim vertex
		wrap_k = ({1'b0, tag_k.fan} + (CFG_RES_W+1)'(1)) >= {1'b0, v_c};
	end

	always_ff @(posedge clk) begin
		if (ld[SK1]) begin
			k1_s14  <= IDX_W'(row_k) * IDX_W'(vp1) + IDX_W'(col_k);
			cen_s14 <= cen_k;
			p1_s14  <= cen_k + IDX_W'(tag_k.fan) + IDX_W'(1);
			p2_s14  <= wrap_k ? (cen_k + IDX_W'(1))
			                  : (cen_k + IDX_W'(tag_k.fan) + IDX_W'(2));
			tag_s14 <= tag_k;
		end
	end

	//------------------------------------------------------------------
	// Stage 15: pick the three indices, wrap them, hold as output register
	//------------------------------------------------------------------
	logic [IDX_W-1:0] k2;
	logic [IDX_W-1:0] k2p1;
	logic [IDX_W-1:0] k1p1;
	logic [IDX_W-1:0] ia;
	logic [IDX_W-1:0] ib;
	logic [IDX_W-1:0] ic;

	logic [IDX_W-1:0] idx_a_s15;
	logic [IDX_W-1:0] idx_b_s15;
	logic [IDX_W-1:0] idx_c_s15;
	region_t          region_s15;

	always_comb begin
		k2   = k1_s14 + IDX_W'(vp1);
		k2p1 = k1_s14 + IDX_W'(vp1) + IDX_W'(1);
		k1p1 = k1_s14 + IDX_W'(1);
		case (tag_s14.region)
			REGION_SIDE: begin
				ia = tag_s14.odd ? k2 : k1_s14;
				ib = tag_s14.odd ? k2p1 : k2;
				ic = k1p1;
			end
			REGION_BOTTOM: begin
				ia = cen_s14;
				ib = p1_s14;
				ic = p2_s14;
			end
			REGION_TOP: begin
				ia = cen_s14;
				ib = p2_s14;
				ic = p1_s14;
			end
			default: begin
				ia = '0;
				ib = '0;
				ic = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[NumStages]) begin
			idx_a_s15  <= ia & IdxMask;
			idx_b_s15  <= ib & IdxMask;
			idx_c_s15  <= ic & IdxMask;
			region_s15 <= tag_s14.region;
		end
	end

	assign m_axis_tvalid = valid_s[NumStages];
	assign m_axis_tdata  = TDATA_OUT_W'({idx_c_s15, idx_b_s15, idx_a_s15});
	assign m_axis_tuser  = region_s15;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	logic in_acc;
	logic out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Input backs up only when every stage is occupied.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (&valid_s))
		else $error("input stalled while the pipeline has a bubble");

	// Items in flight change only by accepted transactions on either side.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(valid_s) == $past($countones(valid_s))
		                   + int'($past(in_acc)) - int'($past(out_acc))))
		else $error("item lost or duplicated inside the pipeline");

	// A triangle beyond the mesh carries all-zero indices.
	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == REGION_BEYOND)) |-> (m_axis_tdata == '0))
		else $error("beyond-mesh result with nonzero indices");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the cylinder mesh triangle indexer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cmti_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int PIPE_LATENCY    = 15;      // input transaction to output transaction
	localparam int CYCLE_LIMIT     = 400000;  // far beyond the slowest correct run
	localparam int HOLD_OFF_CYCLES = 300;     // long output stall that backs up the pipe

	// One triangle as the block reports it.
	typedef struct packed {
		logic [IDX_W-1:0] index_a;
		logic [IDX_W-1:0] index_b;
		logic [IDX_W-1:0] index_c;
		region_t          region;
	} tri_idx_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;   // [20:0] triangle_number
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // [20:0] index_a, [41:21] index_b, [62:42] index_c
	logic [TUSER_OUT_W-1:0] m_axis_tuser;   // [1:0] region
	logic                   cfg_we;
	cfg_index_t             cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Our own copy of the mesh registers, loaded with the reset values.
	logic [CFG_RES_W-1:0] mesh_stacks  = CFG_RES_W'(1);
	logic [CFG_RES_W-1:0] mesh_sectors = CFG_RES_W'(8);
	logic                 mesh_bottom  = 1'b1;
	logic                 mesh_top     = 1'b1;

	tri_idx_t pending_tris[$];   // expected triangles, oldest first
	tri_idx_t exp_tri;
	int       fail_count  = 0;
	int       cycle_count = 0;
	bit       tx_idle_en  = 1'b0;  // random gaps between input transactions
	bit       rx_stall_en = 1'b1;  // random output stalls
	bit       hold_req    = 1'b0;  // ask the receiver for one long hold-off
	bit       hold_done   = 1'b0;  // the receiver has served the hold-off

	cylinder_mesh_triangle_indexer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic tri_idx_t make_tri(input longint unsigned a, input longint unsigned b,
			input longint unsigned c, input region_t r);
		tri_idx_t t;
		t.index_a = IDX_W'(a);
		t.index_b = IDX_W'(b);
		t.index_c = IDX_W'(c);
		t.region  = r;
		return t;
	endfunction

	function automatic longint unsigned clamp_resolution(input logic [CFG_RES_W-1:0] val);
		longint unsigned r;
		r = val;
		if (r > DEF_MAX_RESOLUTION)
			r = DEF_MAX_RESOLUTION;
		return r;
	endfunction

	// Vertex indices of one triangle under the current mesh settings.
	function automatic tri_idx_t predict_triangle(input logic [N_W-1:0] tri_num);
		longint unsigned u, v, n, sides, base_ctr, top_ctr, quad, row, col, k1, k2;
		u = clamp_resolution(mesh_stacks);
		v = clamp_resolution(mesh_sectors);
		n = tri_num;
		// no sectors: the mesh is empty
		if (v == 0)
			return make_tri(0, 0, 0, REGION_BEYOND);
		sides    = 2 * u * v;
		base_ctr = (u + 1) * (v + 1);
		top_ctr  = base_ctr + (mesh_bottom ? v + 1 : 0);
		// side quads, two triangles each
		if (n < sides) begin
			quad = n >> 1;
			row  = quad / v;
			col  = quad % v;
			k1   = row * (v + 1) + col;
			k2   = k1 + v + 1;
			if ((n & 1) == 0)
				return make_tri(k1, k2, k1 + 1, REGION_SIDE);
			return make_tri(k2, k2 + 1, k1 + 1, REGION_SIDE);
		end
		n = n - sides;
		// bottom fan; the last triangle wraps to the first rim vertex
		if (mesh_bottom) begin
			if (n < v)
				return make_tri(base_ctr, base_ctr + 1 + n,
					(n + 1 < v) ? base_ctr + 2 + n : base_ctr + 1, REGION_BOTTOM);
			n = n - v;
		end
		// top fan, wound the other way
		if (mesh_top && n < v)
			return make_tri(top_ctr, (n + 1 < v) ? top_ctr + 2 + n : top_ctr + 1,
				top_ctr + 1 + n, REGION_TOP);
		return make_tri(0, 0, 0, REGION_BEYOND);
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly small meshes, sometimes the extremes.
	function automatic int pick_resolution();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1023;
			2: return $urandom_range(300, 1023);
			3: return 1;
			default: return $urandom_range(2, 24);
		endcase
	endfunction

	// Mostly numbers inside the mesh, with the cap fans favored since the sides dominate.
	function automatic logic [N_W-1:0] pick_triangle();
		longint unsigned u, v, sides, caps, total;
		int unsigned sel;
		u     = clamp_resolution(mesh_stacks);
		v     = clamp_resolution(mesh_sectors);
		sides = (v == 0) ? 0 : 2 * u * v;
		caps  = (v == 0) ? 0 : v * (longint'(mesh_bottom) + longint'(mesh_top));
		total = sides + caps;
		sel   = $urandom_range(0, 19);
		if (sel == 0 || total == 0)
			return N_W'($urandom);
		if (sel == 1)
			return N_W'(total + $urandom_range(0, 3));
		if (sel <= 5 && caps > 0)
			return N_W'(sides + $urandom_range(0, 32'(caps - 1)));
		return N_W'($urandom_range(0, 32'(total - 1)));
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one triangle number; hold it until the transaction completes.
	task automatic send_triangle(input logic [N_W-1:0] tri_num);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = TDATA_IN_W'(tri_num);
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_tris = {pending_tris, predict_triangle(tri_num)};
	endtask

	// Drop valid for a number of cycles, with junk on the data lines.
	task automatic idle_input(input int cycles);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = TDATA_IN_W'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop offering and wait for every expected triangle to come out.
	task automatic drain_results();
		idle_input(1);
		while (pending_tris.size() != 0)
			@(posedge clk);
	endtask

	// Write all four registers on consecutive cycles; the block must be idle.
	task automatic set_mesh(input int u, input int v, input bit bot, input bit top);
		logic [31:0] junk;
		junk = $urandom;
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = CFG_STACK_COUNT;
		cfg_data  = CFG_DATA_W'(u);
		@(negedge clk);
		cfg_index = CFG_SECTOR_COUNT;
		cfg_data  = CFG_DATA_W'(v);
		// only bit 0 of a cap flag counts; fill the rest with noise
		@(negedge clk);
		cfg_index = CFG_WITH_BOTTOM_CAP;
		cfg_data  = {junk[CFG_DATA_W-2:0], bot};
		@(negedge clk);
		cfg_index = CFG_WITH_TOP_CAP;
		cfg_data  = {junk[2*CFG_DATA_W-3:CFG_DATA_W-1], top};
		@(negedge clk);
		cfg_we       = 1'b0;
		mesh_stacks  = CFG_RES_W'(u);
		mesh_sectors = CFG_RES_W'(v);
		mesh_bottom  = bot;
		mesh_top     = top;
	endtask

	task automatic send_directed(input int unsigned nums[$]);
		foreach (nums[i])
			send_triangle(N_W'(nums[i]));
		drain_results();
	endtask

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else if (!rx_stall_en) begin
				m_axis_tready = 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					m_axis_tready = 1'b1;
				end else begin
					m_axis_tready = 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare every output transaction with the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_tris.size() == 0) begin
				$error("unexpected triangle: index_a %0d index_b %0d index_c %0d region %0d",
					m_axis_tdata[IDX_W-1:0], m_axis_tdata[2*IDX_W-1:IDX_W],
					m_axis_tdata[3*IDX_W-1:2*IDX_W], m_axis_tuser);
				fail_count++;
			end else begin
				exp_tri = pending_tris.pop_front();
				if (m_axis_tdata[IDX_W-1:0] !== exp_tri.index_a) begin
					$error("index_a: expected %0d, got %0d", exp_tri.index_a,
						m_axis_tdata[IDX_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[2*IDX_W-1:IDX_W] !== exp_tri.index_b) begin
					$error("index_b: expected %0d, got %0d", exp_tri.index_b,
						m_axis_tdata[2*IDX_W-1:IDX_W]);
					fail_count++;
				end
				if (m_axis_tdata[3*IDX_W-1:2*IDX_W] !== exp_tri.index_c) begin
					$error("index_c: expected %0d, got %0d", exp_tri.index_c,
						m_axis_tdata[3*IDX_W-1:2*IDX_W]);
					fail_count++;
				end
				if (m_axis_tuser !== exp_tri.region) begin
					$error("region: expected %0d, got %0d", exp_tri.region, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("cylinder_mesh_triangle_indexer: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset mesh: 16 side, 8 bottom and 8 top triangles; hit the first side quad, the bottom/top and top/beyond edges.
	task automatic test_reset_mesh();
		int unsigned nums[$];
		nums = {0, 1, 23, 24, 31, 32, 2097151};
		send_directed(nums);
	endtask

	// Empty mesh, no stacks, a single sector and no caps.
	task automatic test_degenerate_meshes();
		int unsigned nums[$];
		set_mesh(5, 0, 1'b1, 1'b1);
		nums = {0};
		send_directed(nums);
		// no side triangles: the fans start at zero and keep their centers
		set_mesh(0, 3, 1'b1, 1'b1);
		nums = {2, 3, 5, 6};
		send_directed(nums);
		// a one-sector fan wraps at once; top center sits at the bottom center slot
		set_mesh(1, 1, 1'b0, 1'b1);
		nums = {2, 3};
		send_directed(nums);
		set_mesh(2, 4, 1'b0, 1'b0);
		nums = {16};
		send_directed(nums);
	endtask

	// Largest mesh: side end, both fan wraps and the first number past the mesh.
	task automatic test_largest_mesh();
		int unsigned nums[$];
		set_mesh(1023, 1023, 1'b1, 1'b1);
		nums = {0, 1, 2093057, 2093058, 2094080, 2094081, 2095103, 2095104};
		send_directed(nums);
	endtask

	// Random meshes with random numbers; every fourth phase runs with no idling.
	task automatic test_random_meshes(input int phases, input int per_phase);
		int gap;
		for (int p = 0; p < phases; p++) begin
			if (p == 0)
				set_mesh(1023, 1023, $urandom_range(0, 1), $urandom_range(0, 1));
			else
				set_mesh(pick_resolution(), pick_resolution(), $urandom_range(0, 1),
					$urandom_range(0, 1));
			tx_idle_en  = (p % 4 != 3);
			rx_stall_en = (p % 4 != 3);
			for (int i = 0; i < per_phase; i++) begin
				send_triangle(pick_triangle());
				gap = tx_idle_en ? pick_gap() : 0;
				if (gap > 0)
					idle_input(gap);
			end
			drain_results();
		end
		rx_stall_en = 1'b1;
	endtask

	// Hold the output off for a long stretch while input keeps coming back to back.
	task automatic test_output_backpressure();
		set_mesh(6, 10, 1'b1, 1'b1);
		tx_idle_en  = 1'b0;
		rx_stall_en = 1'b0;
		hold_req    = 1'b1;
		repeat (80) send_triangle(pick_triangle());
		drain_results();
		rx_stall_en = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_STACK_COUNT;
		cfg_data      = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_mesh();
		test_degenerate_meshes();
		test_largest_mesh();
		test_random_meshes(10, 97);
		test_output_backpressure();

		// catch any stray result after the last expected one
		drain_results();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (fail_count == 0 && pending_tris.size() == 0)
			$display("cylinder_mesh_triangle_indexer: match");
		else
			$display("cylinder_mesh_triangle_indexer: mismatch");
		$finish;
	end

endmodule
